### hw/rtl/rsk_pkg.sv
// Shared types, constants and command codes for the small RSA key unit.
`default_nettype none
package rsk_pkg;
   localparam int PRIME_BITS_DEF = 8;
   localparam int FIELD_W        = 16;
   localparam int STATUS_W       = 3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_PRIME = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_EXP   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_INV    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MSG_BIG   = 3'd4;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_K_RESET, CMD_PRIME_DIV, CMD_K_INC, CMD_SETUP,
      CMD_EU_DIV, CMD_EU_MUL, CMD_EU_UPD, CMD_KEY, CMD_POW_INIT, CMD_SQ,
      CMD_MUL, CMD_ACC, CMD_BIT_DEC, CMD_POW_END, CMD_STATUS, CMD_OUT
   } cmd_op_type;

   typedef enum logic {AR_DIV, AR_MULMOD} arith_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic                sel;
      logic [STATUS_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic arith_done;
      logic rem_zero;
      logic kk_gt;
      logic v_small;
      logic p_eq_q;
      logic e_bad;
      logic r1_zero;
      logic r0_one;
      logic d_zero;
      logic m_big;
      logic exp_bit;
      logic bit_last;
   } stat_type;

   // working width: holds n and phi, never below the 16-bit fields
   function automatic int data_width(input int pb);
      return (2 * pb > FIELD_W) ? 2 * pb : FIELD_W;
   endfunction
endpackage
`default_nettype wire

### hw/rtl/rsk_channels.sv
// Request and response channel interfaces.
`default_nettype none
interface rsk_req_if
   import rsk_pkg::*;
#(parameter int PRIME_BITS = PRIME_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [PRIME_BITS-1:0] prime_p;
   logic [PRIME_BITS-1:0] prime_q;
   logic [FIELD_W-1:0]    public_exp;
   logic [FIELD_W-1:0]    message;
   modport source (output valid, prime_p, prime_q, public_exp, message, input ready);
   modport sink   (input valid, prime_p, prime_q, public_exp, message, output ready);
endinterface

interface rsk_rsp_if
   import rsk_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  modulus;
   logic [FIELD_W-1:0]  private_exp;
   logic [FIELD_W-1:0]  cipher_value;
   logic [FIELD_W-1:0]  plain_again;
   modport source (output valid, status, modulus, private_exp, cipher_value, plain_again,
                   input ready);
   modport sink   (input valid, status, modulus, private_exp, cipher_value, plain_again,
                   output ready);
endinterface
`default_nettype wire

### hw/rtl/rsa_small_keygen_and_crypt_unit.sv
// Top level of the small textbook RSA key check and round-trip unit.
// One item at a time: the request is taken only while the unit is idle, and the
// finished item sits in an output register so the next request can start while
// it waits. Latency depends on the data and is set by a single bit-serial
// divider/modular multiplier of DW = max(2*PRIME_BITS,16) bits: trial division
// up to about sqrt(p)+sqrt(q) uses, two uses per Euclid step, and up to 2*DW
// uses for each of the two exponentiations. Rejected items finish far sooner.
`default_nettype none
module rsa_small_keygen_and_crypt_unit
   import rsk_pkg::*;
#(parameter int PRIME_BITS = PRIME_BITS_DEF) (
   input wire logic clock,
   input wire logic reset,
   rsk_req_if.sink  req_chan,
   rsk_rsp_if.source rsp_chan
);
   cmd_type  cmd;
   stat_type stat;
   logic     ready_w, valid_w;

   rsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready_w),
      .rsp_valid (valid_w),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsk_datapath #(.PRIME_BITS(PRIME_BITS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_p            (req_chan.prime_p),
      .in_q            (req_chan.prime_q),
      .in_e            (req_chan.public_exp),
      .in_m            (req_chan.message),
      .out_status      (rsp_chan.status),
      .out_modulus     (rsp_chan.modulus),
      .out_private_exp (rsp_chan.private_exp),
      .out_cipher      (rsp_chan.cipher_value),
      .out_plain       (rsp_chan.plain_again)
   );

   assign req_chan.ready = ready_w;
   assign rsp_chan.valid = valid_w;
endmodule
`default_nettype wire

### hw/rtl/rsk_arith.sv
// Bit-serial divider and modular multiplier, one bit per cycle.
`default_nettype none
module rsk_arith
   import rsk_pkg::*;
#(parameter int DW = FIELD_W) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  arith_op_type       op,
   input  wire logic [DW-1:0] x,
   input  wire logic [DW-1:0] y,
   input  wire logic [DW-1:0] m,
   output logic               done,
   output logic [DW-1:0]      quo,
   output logic [DW-1:0]      rem
);
   localparam int CW = $clog2(DW);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   arith_op_type  op_ff;
   logic [DW-1:0] q_ff, q_in, r_ff, r_in, y_ff, m_ff;
   logic [DW:0]   sh, t1, t2;

   always_comb begin
      sh = {r_ff, q_ff[DW-1]};
      t1 = {r_ff, 1'b0};
      if (t1 >= {1'b0, m_ff}) t1 = t1 - {1'b0, m_ff};
      t2 = t1 + (q_ff[DW-1] ? {1'b0, y_ff} : '0);
      if (t2 >= {1'b0, m_ff}) t2 = t2 - {1'b0, m_ff};
      if (op_ff == AR_DIV) begin
         if (sh >= {1'b0, y_ff}) begin
            r_in = DW'(sh - {1'b0, y_ff});
            q_in = {q_ff[DW-2:0], 1'b1};
         end else begin
            r_in = sh[DW-1:0];
            q_in = {q_ff[DW-2:0], 1'b0};
         end
      end else begin
         r_in = t2[DW-1:0];
         q_in = {q_ff[DW-2:0], 1'b0};
      end
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= op;
         q_ff  <= x;
         r_ff  <= '0;
         y_ff  <= y;
         m_ff  <= m;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire

### hw/rtl/rsk_datapath.sv
// Key, Euclid and exponentiation registers around the shared arithmetic unit.
`default_nettype none
module rsk_datapath
   import rsk_pkg::*;
#(parameter int PRIME_BITS = PRIME_BITS_DEF) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  wire logic [PRIME_BITS-1:0] in_p,
   input  wire logic [PRIME_BITS-1:0] in_q,
   input  wire logic [FIELD_W-1:0]    in_e,
   input  wire logic [FIELD_W-1:0]    in_m,
   output logic [STATUS_W-1:0]        out_status,
   output logic [FIELD_W-1:0]         out_modulus,
   output logic [FIELD_W-1:0]         out_private_exp,
   output logic [FIELD_W-1:0]         out_cipher,
   output logic [FIELD_W-1:0]         out_plain
);
   localparam int PB = PRIME_BITS;
   localparam int DW = data_width(PRIME_BITS);
   localparam int CW = $clog2(DW);

   logic [PB-1:0]       p_ff, q_ff, k_ff, v;
   logic [FIELD_W-1:0]  e_ff, m_ff;
   logic [DW-1:0]       n_ff, phi_ff, r0_ff, r1_ff, t0_ff, t1_ff, rt_ff, d_ff;
   logic [DW-1:0]       acc_ff, base_ff, exp_ff, c_ff, back_ff;
   logic [CW-1:0]       idx_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [2*PB-1:0]     kk;

   logic          ar_start, ar_done;
   arith_op_type  ar_op;
   logic [DW-1:0] ar_x, ar_y, ar_m, ar_quo, ar_rem;

   assign v  = cmd.sel ? q_ff : p_ff;
   assign kk = (2*PB)'(k_ff) * (2*PB)'(k_ff);

   always_comb begin
      ar_start = 1'b1;
      ar_op    = AR_MULMOD;
      ar_x     = acc_ff;
      ar_y     = acc_ff;
      ar_m     = n_ff;
      case (cmd.op)
         CMD_PRIME_DIV: begin
            ar_op = AR_DIV;
            ar_x  = DW'(v);
            ar_y  = DW'(k_ff);
         end
         CMD_EU_DIV: begin
            ar_op = AR_DIV;
            ar_x  = r0_ff;
            ar_y  = r1_ff;
         end
         CMD_EU_MUL: begin
            ar_x = ar_quo;
            ar_y = t1_ff;
            ar_m = phi_ff;
         end
         CMD_SQ: ;
         CMD_MUL: ar_y = base_ff;
         default: ar_start = 1'b0;
      endcase
   end

   rsk_arith #(.DW(DW)) u_arith (
      .clock (clock),
      .reset (reset),
      .start (ar_start),
      .op    (ar_op),
      .x     (ar_x),
      .y     (ar_y),
      .m     (ar_m),
      .done  (ar_done),
      .quo   (ar_quo),
      .rem   (ar_rem)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            p_ff      <= in_p;
            q_ff      <= in_q;
            e_ff      <= in_e;
            m_ff      <= in_m;
            k_ff      <= PB'(2);
            n_ff      <= '0;
            d_ff      <= '0;
            c_ff      <= '0;
            back_ff   <= '0;
            status_ff <= ST_OK;
         end
         CMD_K_RESET: k_ff <= PB'(2);
         CMD_K_INC:   k_ff <= k_ff + 1'b1;
         CMD_SETUP: begin
            n_ff   <= DW'((2*PB)'(p_ff) * (2*PB)'(q_ff));
            phi_ff <= DW'((2*PB)'(p_ff - 1'b1) * (2*PB)'(q_ff - 1'b1));
            r0_ff  <= DW'((2*PB)'(p_ff - 1'b1) * (2*PB)'(q_ff - 1'b1));
            r1_ff  <= DW'(e_ff);
            t0_ff  <= '0;
            t1_ff  <= DW'(1);
         end
         CMD_EU_MUL: rt_ff <= ar_rem;
         CMD_EU_UPD: begin
            r0_ff <= r1_ff;
            r1_ff <= rt_ff;
            t0_ff <= t1_ff;
            t1_ff <= (t0_ff >= ar_rem) ? t0_ff - ar_rem : t0_ff + (phi_ff - ar_rem);
         end
         CMD_KEY: d_ff <= t0_ff;
         CMD_POW_INIT: begin
            acc_ff  <= DW'(1);
            base_ff <= cmd.sel ? c_ff : DW'(m_ff);
            exp_ff  <= cmd.sel ? d_ff : DW'(e_ff);
            idx_ff  <= CW'(DW - 1);
         end
         CMD_ACC:     acc_ff <= ar_rem;
         CMD_BIT_DEC: idx_ff <= idx_ff - 1'b1;
         CMD_POW_END: begin
            if (cmd.sel) back_ff <= acc_ff;
            else         c_ff    <= acc_ff;
         end
         CMD_STATUS: status_ff <= cmd.code;
         CMD_OUT: begin
            out_status      <= status_ff;
            out_modulus     <= n_ff[FIELD_W-1:0];
            out_private_exp <= d_ff[FIELD_W-1:0];
            out_cipher      <= c_ff[FIELD_W-1:0];
            out_plain       <= back_ff[FIELD_W-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.arith_done = ar_done;
      stat.rem_zero   = (ar_rem == '0);
      stat.kk_gt      = (kk > (2*PB)'(v));
      stat.v_small    = (v < PB'(2));
      stat.p_eq_q     = (p_ff == q_ff);
      stat.e_bad      = (e_ff <= FIELD_W'(1)) || (DW'(e_ff) >= phi_ff);
      stat.r1_zero    = (r1_ff == '0);
      stat.r0_one     = (r0_ff == DW'(1));
      stat.d_zero     = (d_ff == '0);
      stat.m_big      = (DW'(m_ff) >= n_ff);
      stat.exp_bit    = exp_ff[idx_ff];
      stat.bit_last   = (idx_ff == '0);
   end
endmodule
`default_nettype wire

### hw/rtl/rsk_ctrl.sv
// Sequencer: prime checks, Euclid, two exponentiations, response handshake.
`default_nettype none
module rsk_ctrl
   import rsk_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  stat_type  stat,
   output cmd_type   cmd
);
   typedef enum logic [16:0] {
      S_IDLE    = 17'h00001, S_P_CHK   = 17'h00002, S_P_WAIT  = 17'h00004,
      S_SETUP   = 17'h00008, S_E_CHK   = 17'h00010, S_EU_TEST = 17'h00020,
      S_EU_DIVW = 17'h00040, S_EU_MULW = 17'h00080, S_D_CHK   = 17'h00100,
      S_PW_SQ   = 17'h00200, S_PW_SQW  = 17'h00400, S_PW_BIT  = 17'h00800,
      S_PW_MULW = 17'h01000, S_PW_NEXT = 17'h02000, S_PW_END  = 17'h04000,
      S_PW_RST  = 17'h08000, S_FIN     = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in, rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = CMD_NONE;
      cmd.sel      = sel_ff;
      cmd.code     = ST_OK;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op   = CMD_LOAD;
            sel_in   = 1'b0;
            state_in = S_P_CHK;
         end
         S_P_CHK: begin
            if (stat.v_small) begin
               cmd.op   = CMD_STATUS;
               cmd.code = ST_NOT_PRIME;
               state_in = S_FIN;
            end else if (stat.kk_gt) begin
               if (!sel_ff) begin
                  cmd.op = CMD_K_RESET;
                  sel_in = 1'b1;
               end else if (stat.p_eq_q) begin
                  cmd.op   = CMD_STATUS;
                  cmd.code = ST_NOT_PRIME;
                  state_in = S_FIN;
               end else begin
                  state_in = S_SETUP;
               end
            end else begin
               cmd.op   = CMD_PRIME_DIV;
               state_in = S_P_WAIT;
            end
         end
         S_P_WAIT: if (stat.arith_done) begin
            if (stat.rem_zero) begin
               cmd.op   = CMD_STATUS;
               cmd.code = ST_NOT_PRIME;
               state_in = S_FIN;
            end else begin
               cmd.op   = CMD_K_INC;
               state_in = S_P_CHK;
            end
         end
         S_SETUP: begin
            cmd.op   = CMD_SETUP;
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            if (stat.e_bad) begin
               cmd.op   = CMD_STATUS;
               cmd.code = ST_BAD_EXP;
               state_in = S_FIN;
            end else begin
               state_in = S_EU_TEST;
            end
         end
         S_EU_TEST: begin
            if (!stat.r1_zero) begin
               cmd.op   = CMD_EU_DIV;
               state_in = S_EU_DIVW;
            end else if (!stat.r0_one) begin
               cmd.op   = CMD_STATUS;
               cmd.code = ST_BAD_EXP;
               state_in = S_FIN;
            end else begin
               cmd.op   = CMD_KEY;
               state_in = S_D_CHK;
            end
         end
         S_EU_DIVW: if (stat.arith_done) begin
            cmd.op   = CMD_EU_MUL;
            state_in = S_EU_MULW;
         end
         S_EU_MULW: if (stat.arith_done) begin
            cmd.op   = CMD_EU_UPD;
            state_in = S_EU_TEST;
         end
         S_D_CHK: begin
            if (stat.d_zero) begin
               cmd.op   = CMD_STATUS;
               cmd.code = ST_NO_INV;
               state_in = S_FIN;
            end else if (stat.m_big) begin
               cmd.op   = CMD_STATUS;
               cmd.code = ST_MSG_BIG;
               state_in = S_FIN;
            end else begin
               cmd.op   = CMD_POW_INIT;
               cmd.sel  = 1'b0;
               sel_in   = 1'b0;
               state_in = S_PW_SQ;
            end
         end
         S_PW_SQ: begin
            cmd.op   = CMD_SQ;
            state_in = S_PW_SQW;
         end
         S_PW_SQW: if (stat.arith_done) begin
            cmd.op   = CMD_ACC;
            state_in = S_PW_BIT;
         end
         S_PW_BIT: begin
            if (stat.exp_bit) begin
               cmd.op   = CMD_MUL;
               state_in = S_PW_MULW;
            end else begin
               state_in = S_PW_NEXT;
            end
         end
         S_PW_MULW: if (stat.arith_done) begin
            cmd.op   = CMD_ACC;
            state_in = S_PW_NEXT;
         end
         S_PW_NEXT: begin
            if (stat.bit_last) begin
               state_in = S_PW_END;
            end else begin
               cmd.op   = CMD_BIT_DEC;
               state_in = S_PW_SQ;
            end
         end
         S_PW_END: begin
            cmd.op   = CMD_POW_END;
            state_in = sel_ff ? S_FIN : S_PW_RST;
         end
         S_PW_RST: begin
            cmd.op   = CMD_POW_INIT;
            cmd.sel  = 1'b1;
            sel_in   = 1'b1;
            state_in = S_PW_SQ;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // status starts at OK on LOAD and is overwritten only by a failed check
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/rsk_checker.sv
// Port-level assertions for the RSA key unit, bound to the top level.
`default_nettype none
module rsk_checker
   import rsk_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] status,
   input wire logic [FIELD_W-1:0]  modulus,
   input wire logic [FIELD_W-1:0]  private_exp,
   input wire logic [FIELD_W-1:0]  cipher_value,
   input wire logic [FIELD_W-1:0]  plain_again
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(cipher_value))
      else $error("stalled item changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= ST_MSG_BIG)
      else $error("status code out of range");

   a_not_prime_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_NOT_PRIME |-> modulus == '0 && private_exp == '0)
      else $error("key fields set on rejected primes");

   a_fail_no_cipher: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> cipher_value == '0 && plain_again == '0)
      else $error("cipher given on a failed item");
endmodule

bind rsa_small_keygen_and_crypt_unit rsk_checker u_rsk_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .modulus      (rsp_chan.modulus),
   .private_exp  (rsp_chan.private_exp),
   .cipher_value (rsp_chan.cipher_value),
   .plain_again  (rsp_chan.plain_again)
);
`default_nettype wire

### tb/rsk_tb_checker.sv
// Checker for the RSA key unit: predicts each result from the accepted request and compares.
`timescale 1ns / 1ps
module rsk_tb_checker
   import rsk_pkg::*;
#(parameter int PRIME_BITS = PRIME_BITS_DEF) (
   input wire logic clock,
   input wire logic reset,
   rsk_req_if       req_mon,
   rsk_rsp_if       rsp_mon,
   output int       fail_count,
   output int       pending_count
);
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  modulus;
      logic [FIELD_W-1:0]  private_exp;
      logic [FIELD_W-1:0]  cipher_value;
      logic [FIELD_W-1:0]  plain_again;
   } key_result_type;

   key_result_type expected_keys[$];

   function automatic bit is_prime(longint unsigned v);
      longint unsigned k;
      if (v < 2) return 0;
      for (k = 2; k * k <= v; k++)
         if (v % k == 0) return 0;
      return 1;
   endfunction

   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic longint unsigned inverse_of(longint unsigned a, longint unsigned m);
      longint r0, r1, t0, t1, qt, tmp;
      r0 = m;
      r1 = a % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         qt = r0 / r1;
         tmp = r0 - qt * r1;
         r0 = r1;
         r1 = tmp;
         tmp = t0 - qt * t1;
         t0 = t1;
         t1 = tmp;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 += m;
      return t0;
   endfunction

   function automatic longint unsigned power_mod(longint unsigned b, longint unsigned x,
                                                 longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      b = b % m;
      while (x != 0) begin
         if (x[0]) acc = (acc * b) % m;
         b = (b * b) % m;
         x = x >> 1;
      end
      return acc;
   endfunction

   function automatic key_result_type predict_keys(longint unsigned p, longint unsigned q,
                                                   longint unsigned e, longint unsigned m);
      key_result_type r;
      longint unsigned n, phi, d, c, back;
      logic [STATUS_W-1:0] st;
      n = 0; d = 0; c = 0; back = 0;
      st = ST_OK;
      if (!is_prime(p) || !is_prime(q) || p == q) begin
         st = ST_NOT_PRIME;
      end else begin
         n = p * q;
         phi = (p - 1) * (q - 1);
         if (e <= 1 || e >= phi || gcd_of(e, phi) != 1) begin
            st = ST_BAD_EXP;
         end else begin
            d = inverse_of(e, phi);
            if (d == 0) st = ST_NO_INV;
            else if (m >= n) st = ST_MSG_BIG;
            else begin
               c = power_mod(m, e, n);
               back = power_mod(c, d, n);
            end
         end
      end
      r.status = st;
      r.modulus = n[FIELD_W-1:0];
      r.private_exp = d[FIELD_W-1:0];
      r.cipher_value = c[FIELD_W-1:0];
      r.plain_again = back[FIELD_W-1:0];
      return r;
   endfunction

   assign pending_count = expected_keys.size();

   always @(posedge clock) begin
      key_result_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_keys.push_back(predict_keys(req_mon.prime_p, req_mon.prime_q,
                                                 req_mon.public_exp, req_mon.message));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_keys.size() == 0) begin
               $error("unexpected result item");
               errs++;
            end else begin
               want = expected_keys.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_mon.status);
                  errs++;
               end
               if (rsp_mon.modulus !== want.modulus) begin
                  $error("modulus expected %0d got %0d", want.modulus, rsp_mon.modulus);
                  errs++;
               end
               if (rsp_mon.private_exp !== want.private_exp) begin
                  $error("private_exp expected %0d got %0d", want.private_exp,
                         rsp_mon.private_exp);
                  errs++;
               end
               if (rsp_mon.cipher_value !== want.cipher_value) begin
                  $error("cipher_value expected %0d got %0d", want.cipher_value,
                         rsp_mon.cipher_value);
                  errs++;
               end
               if (rsp_mon.plain_again !== want.plain_again) begin
                  $error("plain_again expected %0d got %0d", want.plain_again,
                         rsp_mon.plain_again);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

### tb/rsa_small_keygen_and_crypt_unit_tb.sv
// Testbench top for the RSA key unit: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module rsa_small_keygen_and_crypt_unit_tb;
   import rsk_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   timed_out;

   rsk_req_if req_chan ();
   rsk_rsp_if rsp_chan ();

   rsa_small_keygen_and_crypt_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   rsk_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   byte unsigned prime_list[$] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
      59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149,
      151, 157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233, 239,
      241, 251};

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_key(input logic [7:0] p, input logic [7:0] q,
                           input logic [15:0] e, input logic [15:0] m);
      @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_chan.valid <= 1;
      req_chan.prime_p <= p;
      req_chan.prime_q <= q;
      req_chan.public_exp <= e;
      req_chan.message <= m;
      do @(posedge clock); while (!req_chan.ready);
      req_chan.valid <= 0;
   endtask

   task automatic send_random_key();
      logic [7:0] p, q;
      int phi, e, n;
      if ($urandom_range(9) < 8) begin
         p = prime_list[$urandom_range(prime_list.size() - 1)];
         q = prime_list[$urandom_range(prime_list.size() - 1)];
      end else begin
         p = 8'($urandom);
         q = 8'($urandom);
      end
      n = p * q;
      phi = (p - 1) * (q - 1);
      if (phi > 3 && $urandom_range(9) < 8) e = $urandom_range(phi - 1, 2);
      else e = $urandom_range(65535);
      if (n > 0 && $urandom_range(9) < 8)
         send_key(p, q, 16'(e), 16'($urandom_range(n - 1)));
      else
         send_key(p, q, 16'(e), 16'($urandom_range(65535)));
   endtask

   initial begin
      reset = 1;
      timed_out = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_chan.valid = 0;
      req_chan.prime_p = 0;
      req_chan.prime_q = 0;
      req_chan.public_exp = 0;
      req_chan.message = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_key(0, 0, 0, 0);
      send_key(1, 3, 3, 1);
      send_key(7, 7, 5, 1);
      send_key(255, 251, 7, 0);
      send_key(11, 13, 0, 5);
      send_key(11, 13, 1, 5);
      send_key(11, 13, 120, 5);
      send_key(11, 13, 65535, 5);
      send_key(11, 13, 6, 5);
      send_key(11, 13, 7, 143);
      send_key(11, 13, 7, 65535);
      send_key(11, 13, 7, 0);
      send_key(11, 13, 7, 142);
      send_key(251, 241, 7, 60490);
      send_key(251, 241, 59999, 12345);
      send_key(241, 251, 7, 16'hAAAA);
      send_key(2, 3, 3, 5);
      send_key(2, 251, 3, 16'h5555);
      send_key(128, 3, 3, 1);

      wait (pending_count == 0);
      repeat (20) @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 62 : 35) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 62 : 35) : 0;
         repeat (25) send_random_key();
      end

      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
